@@ rtl/assert_macros.svh @@
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, ignored while rst_n is low
`define FSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, ignored while rst_n is low
`define FSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fsd_pkg.sv @@
// shared types and constants for the float to scaled decimal converter
package fsd_pkg;

    // datapath width: holds V * 10^7 and the shifted divisor, both below 2^269
    localparam int DP_W       = 270;
    localparam int FRAC_SHIFT = 149;
    localparam int COEF_W     = 96;
    localparam int MANT_W     = 24;
    localparam int SCALE_W    = 5;

    localparam logic [SCALE_W-1:0] MAX_SCALE  = 5'd28;
    localparam logic [SCALE_W-1:0] MAX_DECADE = 5'd29;
    localparam logic [7:0]         EXP_SPECIAL = 8'd255;
    // biased exponents from here up are at or above 2^96
    localparam logic [7:0]         EXP_TOO_BIG = 8'd223;

    localparam logic [MANT_W-1:0] TEN_MILLION = 24'd10000000;
    localparam logic [MANT_W-1:0] ONE_MILLION = 24'd1000000;

    localparam logic [DP_W-1:0] ONE_FIX   = DP_W'(1) << FRAC_SHIFT;
    // 999999.5 in the fixed-point domain
    localparam logic [DP_W-1:0] SMALL_THR = DP_W'(21'd1999999) << (FRAC_SHIFT - 1);

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic ge;    // a >= b on a subtract
        logic zero;  // result is zero
    } alu_flags_t;

endpackage

@@ rtl/fsd_alu.sv @@
// wide shared adder / subtractor with compare flags
module fsd_alu
    import fsd_pkg::*;
(
    input  alu_op_t          op,
    input  logic [DP_W-1:0]  a,
    input  logic [DP_W-1:0]  b,
    output logic [DP_W-1:0]  res,
    output alu_flags_t       flags
);

    logic [DP_W:0] sum;
    logic [DP_W-1:0] b_in;

    assign b_in = (op == ALU_SUB) ? ~b : b;
    assign sum  = {1'b0, a} + {1'b0, b_in} + {{DP_W{1'b0}}, (op == ALU_SUB)};
    assign res  = sum[DP_W-1:0];

    always_comb
    begin
        flags.ge   = sum[DP_W];
        flags.zero = (sum[DP_W-1:0] == '0);
    end

endmodule

@@ rtl/fsd_div10.sv @@
// divide a narrow coefficient by ten through a reciprocal multiply
module fsd_div10
    import fsd_pkg::*;
(
    input  logic [MANT_W-1:0] value,
    output logic [MANT_W-1:0] quot,
    output logic [3:0]        rem
);

    logic [MANT_W+31:0] prod;
    logic [MANT_W-1:0]  times_ten;

    assign prod      = {32'd0, value} * {{MANT_W{1'b0}}, 32'hCCCCCCCD};
    // the quotient of a 24-bit value fits in 21 bits
    assign quot      = {3'b000, prod[MANT_W+31:35]};
    assign times_ten = (quot << 3) + (quot << 1);
    assign rem       = 4'(value - times_ten);

endmodule

@@ rtl/float_to_scaled_decimal.sv @@
// top level: binary32 to 96-bit scaled decimal converter
//
//  channel   dir  width  content
//  s_axis    in   32     binary32 bit pattern
//  m_axis    out  104    coefficient, scale, sign; tuser carries the error flag
//
// zero, NaN, infinity and overflowing inputs go straight to the done state; the rest
// runs step by step on the single 270-bit adder, which does every multiply by ten,
// every compare against a threshold or a power of ten and every restoring division
// step; small values compare and multiply once per decade scaled, then round; larger
// ones per decade searched, then 7 scaling and 24 division steps, rounding and a fixup
// s_axis_tready is high only while the sequencer is idle; a finished result sits in
// the output register, so a new input is taken while the last result is unread
// rst_n clears the sequencer and the output valid asynchronously
module float_to_scaled_decimal
    import fsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] float_bits
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // [63:0] coefficient_low, [95:64] coefficient_high,
                                         // [100:96] decimal_scale, [101] negative, zero pad
    output logic         m_axis_tuser    // [0] status
);

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_CHK_MUL = 13'b0000000000010,
        ST_CHK_CMP = 13'b0000000000100,
        ST_SM_CMP  = 13'b0000000001000,
        ST_SM_MUL  = 13'b0000000010000,
        ST_LG_CMP  = 13'b0000000100000,
        ST_LG_MUL  = 13'b0000001000000,
        ST_SCL_MUL = 13'b0000010000000,
        ST_DIV     = 13'b0000100000000,
        ST_RND     = 13'b0001000000000,
        ST_EXP_MUL = 13'b0010000000000,
        ST_STRIP   = 13'b0100000000000,
        ST_DONE    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // working registers: acc holds V, the scaled value, the remainder or the coefficient
    logic [DP_W-1:0]    acc_reg, acc_next;
    logic [DP_W-1:0]    ref_reg, ref_next;
    logic [MANT_W-1:0]  q_reg, q_next;
    logic [SCALE_W-1:0] exp_reg, exp_next;
    logic [SCALE_W-1:0] step_reg, step_next;
    logic               neg_reg, neg_next;
    logic               err_reg, err_next;

    logic               out_valid_reg, out_valid_next;
    logic [103:0]       out_data_reg, out_data_next;
    logic               out_err_reg, out_err_next;

    // shared unit
    alu_op_t            alu_op;
    logic [DP_W-1:0]    alu_a, alu_b, alu_res;
    alu_flags_t         alu_flags;

    // strip divider
    logic [MANT_W-1:0]  d10_quot;
    logic [3:0]         d10_rem;

    // input decode
    logic               in_sign;
    logic [7:0]         in_exp;
    logic [22:0]        in_frac;
    logic [MANT_W-1:0]  in_mant;
    logic [7:0]         in_shift;

    // rounding helpers
    logic [MANT_W-1:0]  sm_ip, sm_n, rnd_mm;
    logic               sm_up, rnd_up;
    logic [SCALE_W-1:0] rnd_exp;
    logic               load_out;

    fsd_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .flags (alu_flags)
    );

    fsd_div10 u_div10 (
        .value (acc_reg[MANT_W-1:0]),
        .quot  (d10_quot),
        .rem   (d10_rem)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_err_reg;

    assign in_sign  = s_axis_tdata[31];
    assign in_exp   = s_axis_tdata[30:23];
    assign in_frac  = s_axis_tdata[22:0];
    assign in_mant  = {(in_exp != 8'd0), in_frac};
    assign in_shift = (in_exp != 8'd0) ? in_exp - 8'd1 : 8'd0;

    // half-even rounding of the small-path value at the binary point
    assign sm_ip = acc_reg[FRAC_SHIFT +: MANT_W];
    assign sm_up = acc_reg[FRAC_SHIFT-1]
                   & ((|acc_reg[FRAC_SHIFT-2:0]) | sm_ip[0]);
    assign sm_n  = sm_ip + {{(MANT_W-1){1'b0}}, sm_up};

    // half-even rounding of the quotient from twice the remainder against the divisor
    assign rnd_up  = (alu_flags.ge & ~alu_flags.zero) | (alu_flags.zero & q_reg[0]);
    assign rnd_mm  = q_reg + {{(MANT_W-1){1'b0}}, rnd_up};
    assign rnd_exp = (rnd_mm == TEN_MILLION) ? exp_reg + 5'd1 : exp_reg;

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    // operand selection for the shared unit
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            ST_CHK_MUL, ST_SM_MUL, ST_SCL_MUL, ST_EXP_MUL:
            begin
                alu_a = acc_reg << 3;
                alu_b = acc_reg << 1;
            end
            ST_LG_MUL:
            begin
                alu_a = ref_reg << 3;
                alu_b = ref_reg << 1;
            end
            ST_SM_CMP:
            begin
                alu_op = ALU_SUB;
                alu_a  = acc_reg;
                alu_b  = SMALL_THR;
            end
            ST_LG_CMP, ST_DIV:
            begin
                alu_op = ALU_SUB;
                alu_a  = acc_reg;
                alu_b  = ref_reg;
            end
            ST_RND:
            begin
                alu_op = ALU_SUB;
                alu_a  = acc_reg << 1;
                alu_b  = ref_reg;
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        ref_next   = ref_reg;
        q_next     = q_reg;
        exp_next   = exp_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    neg_next  = in_sign;
                    exp_next  = '0;
                    step_next = '0;
                    q_next    = '0;
                    if (in_exp == EXP_SPECIAL || in_exp >= EXP_TOO_BIG)
                    begin
                        err_next   = 1'b1;
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end
                    else if (in_exp == 8'd0 && in_frac == 23'd0)
                    begin
                        err_next   = 1'b0;
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        acc_next   = DP_W'(in_mant) << in_shift;
                        state_next = ST_CHK_MUL;
                    end
                end
            end
            ST_CHK_MUL:
            begin
                ref_next   = alu_res;
                state_next = ST_CHK_CMP;
            end
            ST_CHK_CMP:
            begin
                // below 0.1 when ten times the value has no integer part
                if (ref_reg[DP_W-1:FRAC_SHIFT] == '0)
                begin
                    acc_next   = ref_reg;
                    exp_next   = 5'd1;
                    state_next = ST_SM_CMP;
                end
                else
                begin
                    ref_next   = ONE_FIX;
                    exp_next   = '0;
                    state_next = ST_LG_CMP;
                end
            end
            ST_SM_CMP:
            begin
                if (exp_reg == MAX_SCALE || alu_flags.ge)
                begin
                    err_next = (acc_reg[DP_W-1:FRAC_SHIFT] == '0);
                    if (sm_n == TEN_MILLION && exp_reg != 5'd0)
                    begin
                        acc_next = DP_W'(ONE_MILLION);
                        exp_next = exp_reg - 5'd1;
                    end
                    else
                    begin
                        acc_next = DP_W'(sm_n);
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SM_MUL;
                end
            end
            ST_SM_MUL:
            begin
                acc_next   = alu_res;
                exp_next   = exp_reg + 5'd1;
                state_next = ST_SM_CMP;
            end
            ST_LG_CMP:
            begin
                // exp counts decades: ref is 10^exp at the binary point
                if (exp_reg == MAX_DECADE || !alu_flags.ge)
                begin
                    step_next  = '0;
                    state_next = ST_SCL_MUL;
                end
                else
                begin
                    state_next = ST_LG_MUL;
                end
            end
            ST_LG_MUL:
            begin
                ref_next   = alu_res;
                exp_next   = exp_reg + 5'd1;
                state_next = ST_LG_CMP;
            end
            ST_SCL_MUL:
            begin
                acc_next = alu_res;
                if (step_reg == 5'd6)
                begin
                    step_next  = '0;
                    ref_next   = ref_reg << (MANT_W - 1);
                    state_next = ST_DIV;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_DIV:
            begin
                if (alu_flags.ge)
                begin
                    acc_next = alu_res;
                end
                q_next = {q_reg[MANT_W-2:0], alu_flags.ge};
                if (step_reg == 5'(MANT_W - 1))
                begin
                    state_next = ST_RND;
                end
                else
                begin
                    ref_next  = ref_reg >> 1;
                    step_next = step_reg + 5'd1;
                end
            end
            ST_RND:
            begin
                acc_next = (rnd_mm == TEN_MILLION) ? DP_W'(ONE_MILLION) : DP_W'(rnd_mm);
                if (rnd_exp > 5'd7)
                begin
                    step_next  = rnd_exp - 5'd7;
                    exp_next   = '0;
                    state_next = ST_EXP_MUL;
                end
                else
                begin
                    exp_next   = 5'd7 - rnd_exp;
                    state_next = ST_STRIP;
                end
            end
            ST_EXP_MUL:
            begin
                acc_next  = alu_res;
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd1)
                begin
                    err_next   = (alu_res[DP_W-1:COEF_W] != '0);
                    state_next = ST_DONE;
                end
            end
            ST_STRIP:
            begin
                if (exp_reg != 5'd0 && d10_rem == 4'd0)
                begin
                    acc_next = DP_W'(d10_quot);
                    exp_next = exp_reg - 5'd1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_err_next   = err_reg;
            if (err_reg)
            begin
                out_data_next = '0;
            end
            else
            begin
                out_data_next = {2'b00, neg_reg, exp_reg, acc_reg[COEF_W-1:0]};
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        ref_reg      <= ref_next;
        q_reg        <= q_next;
        exp_reg      <= exp_next;
        step_reg     <= step_next;
        neg_reg      <= neg_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
    end

endmodule

@@ rtl/fsd_checker.sv @@
// port-level checks on the converter, bound to the top level
`include "assert_macros.svh"

module fsd_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // a result waiting for the sink stays offered
    `FSD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    // an error transaction carries an all-zero payload
    `FSD_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 104'd0, "error result with payload")
    // the scale never exceeds 28
    `FSD_ASSERT_NOW(a_scale_max, m_axis_tvalid, m_axis_tdata[100:96] <= 5'd28, "scale out of range")
    // the converter is not ready again in the cycle after it takes an input
    `FSD_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

endmodule

bind float_to_scaled_decimal fsd_checker u_fsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ sim/float_to_scaled_decimal_checker.sv @@
// checker for the float to scaled decimal converter: predicts each result and compares
`timescale 1ns / 1ps

module float_to_scaled_decimal_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           fail_count,
    output int           pending
);

    typedef logic [399:0] wide_t;

    typedef struct packed {
        logic [63:0] coef_lo;
        logic [31:0] coef_hi;
        logic [4:0]  scale;
        logic        negative;
        logic        status;
    } decimal_t;

    localparam int FRAC = 149;
    localparam int TOP_SCALE = 28;

    decimal_t decimal_q[$];

    function automatic wide_t pow_ten(input int k);
        wide_t r;
        r = wide_t'(1);
        for (int i = 0; i < k; i++) r = r * wide_t'(10);
        return r;
    endfunction

    // half-even rounding of t / 2^FRAC, sticky marks dropped digits further down
    function automatic logic [63:0] round_fixed(input wide_t t, input logic sticky);
        logic [63:0] ip;
        logic below;
        ip = 64'(t >> FRAC);
        below = sticky || (t[FRAC-2:0] != '0);
        if (t[FRAC-1] && (below || ip[0])) ip = ip + 64'd1;
        return ip;
    endfunction

    function automatic decimal_t convert_float(input logic [31:0] x);
        decimal_t r;
        logic [7:0] ex;
        logic [22:0] fr;
        wide_t v, t, one, coef, q;
        logic [63:0] n;
        int scale, e10, a;
        logic sticky;
        r = '0;
        ex = x[30:23];
        fr = x[22:0];
        one = wide_t'(1) << FRAC;
        if (ex == 8'hff) begin
            r.status = 1'b1;
            return r;
        end
        if (ex == 8'h00 && fr == '0) begin
            r.negative = x[31];
            return r;
        end
        v = wide_t'({(ex != 0), fr}) << ((ex != 0) ? ex - 1 : 0);
        if (v >= (wide_t'(1) << (96 + FRAC)) || v * pow_ten(TOP_SCALE) < one) begin
            r.status = 1'b1;
            return r;
        end
        if (v * wide_t'(10) < one) begin
            // tiny values: scale up by decades toward 999999.5
            t = v;
            scale = 0;
            while (scale < TOP_SCALE && t * wide_t'(2) < (wide_t'(1999999) << FRAC)) begin
                t = t * wide_t'(10);
                scale++;
            end
            n = round_fixed(t, 1'b0);
            if (n >= 64'd10000000 && scale > 0) begin
                n = n / 64'd10;
                scale--;
            end
            coef = wide_t'(n);
        end else begin
            // seven significant digits
            e10 = -1;
            while (e10 < TOP_SCALE && v >= one * pow_ten(e10 + 1)) e10++;
            a = 6 - e10;
            if (a >= 0) begin
                n = round_fixed(v * pow_ten(a), 1'b0);
            end else begin
                q = v / pow_ten(-a);
                sticky = (v % pow_ten(-a)) != '0;
                n = round_fixed(q, sticky);
            end
            if (n >= 64'd10000000) begin
                n = n / 64'd10;
                e10++;
            end
            coef = wide_t'(n);
            if (e10 > 6) begin
                coef = coef * pow_ten(e10 - 6);
                scale = 0;
            end else begin
                scale = 6 - e10;
                while (scale > 0 && coef % wide_t'(10) == '0) begin
                    coef = coef / wide_t'(10);
                    scale--;
                end
            end
        end
        if (coef >= (wide_t'(1) << 96)) begin
            r.status = 1'b1;
            return r;
        end
        r.coef_lo = coef[63:0];
        r.coef_hi = coef[95:64];
        r.scale = 5'(scale);
        r.negative = x[31];
        return r;
    endfunction

    assign pending = decimal_q.size();

    always @(posedge clk or negedge rst_n) begin
        decimal_t want, got;
        if (!rst_n) begin
            fail_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                decimal_q.push_back(convert_float(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[63:0], m_axis_tdata[95:64], m_axis_tdata[100:96],
                       m_axis_tdata[101], m_axis_tuser};
                if (decimal_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transaction %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = decimal_q.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("mismatch: coef %h_%h scale %0d neg %b err %b, got %h_%h scale %0d neg %b err %b",
                                     want.coef_hi, want.coef_lo, want.scale, want.negative,
                                     want.status, got.coef_hi, got.coef_lo, got.scale,
                                     got.negative, got.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ sim/tb_float_to_scaled_decimal.sv @@
// top of the float to scaled decimal testbench: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_float_to_scaled_decimal;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 1200;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tuser;
    int           fail_count;
    int           pending;
    int           cycles;
    int           sent;

    float_to_scaled_decimal uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // watches both channels and keeps the running failure count
    float_to_scaled_decimal_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog against a hung handshake
    initial cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_float_to_scaled_decimal failed");
            $finish;
        end
    end

    // receiver back-pressure: the mode steps through 0 to 3 as the cycle counter advances
    // mode 0 never stalls, modes 1 and 3 stall half the time, mode 2 is ready one time in eight
    initial m_axis_tready = 1'b0;
    always @(negedge clk) begin
        case ((cycles / 256) % 4)
            0:       m_axis_tready <= 1'b1;
            1, 3:    m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // one transaction on the input channel; called and left at a falling edge
    task automatic send_float(input logic [31:0] bits);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bits;
        // tready is a registered idle flag, so its value now holds through the next edge
        while (!s_axis_tready) @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic idle_gap(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // random binary32, mostly with exponents in the convertible span
    function automatic logic [31:0] random_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(0, 9))
            0:       ;                                          // any pattern
            1:       f[30:23] = 8'($urandom_range(25, 45));     // near the too-small limit
            2:       f[30:23] = 8'($urandom_range(210, 223));   // near the too-large limit
            3:       f[30:23] = 8'($urandom_range(118, 150));   // around the seven digit span
            4:       f[22:0]  = 23'($urandom_range(0, 3)) << 20; // few significant bits, ties
            default: f[30:23] = 8'($urandom_range(34, 222));
        endcase
        return f;
    endfunction

    logic [31:0] directed_floats[] = '{
        32'h0000_0000, 32'h8000_0000,   // signed zeros
        32'h7f80_0000, 32'hff80_0000,   // infinities
        32'h7fc0_0000, 32'hff80_0001,   // nans
        32'h0000_0001, 32'h807f_ffff,   // subnormals are too small
        32'h1000_0000, 32'h1200_0000,   // around 1e-28
        32'h3dcc_cccd, 32'h3dcc_cccc,   // either side of 0.1
        32'h3f80_0000, 32'hbf00_0000,   // 1 and -0.5
        32'h4996_b43c,                  // 1234567.5, tie to even
        32'h4b18_967f, 32'h4b18_9680,   // 9999999 and 10000000
        32'h4b7f_ffff, 32'h4b00_0001,   // 16777215 and 8388609
        32'h6f7f_ffff, 32'hef80_0000,   // largest convertible, then 2^96
        32'h3380_0000, 32'h2f3f_ffff    // small path, carry at the decade edge
    };

    initial begin
        int burst;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        sent = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_floats[i]) send_float(directed_floats[i]);

        while (sent < RANDOM_ITEMS + directed_floats.size()) begin
            burst = $urandom_range(1, 20);
            repeat (burst) send_float(random_float());
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 150));
            // halfway through let the converter drain completely at least once
            if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 21) begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
                while (pending != 0) @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);

        if (fail_count == 0)
            $display("tb_float_to_scaled_decimal passed");
        else
            $display("tb_float_to_scaled_decimal failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/fsd_pkg.sv
rtl/fsd_alu.sv
rtl/fsd_div10.sv
rtl/float_to_scaled_decimal.sv
rtl/fsd_checker.sv
sim/float_to_scaled_decimal_checker.sv
sim/tb_float_to_scaled_decimal.sv
